// File: rtl/assert_macros.svh
// Assertion helpers for the particle step checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// File: rtl/cap_pkg.sv
package cap_pkg;
  localparam int FracBits = 12;
  localparam int GravFrac = 12;
  localparam logic [6:0] Soften = 7'd120;
  localparam logic [11:0] Gain = 12'd2200;
  localparam logic [15:0] DampQ16 = 16'd65012;
  localparam logic [23:0] Max24 = 24'h7FFFFF;
  localparam logic [23:0] Min24 = 24'h800000;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_code_t;

  localparam logic [1:0] RegCenterX = 2'd0;
  localparam logic [1:0] RegCenterY = 2'd1;
  localparam logic [1:0] RegGravity = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic signed [23:0] load_x;
    logic signed [23:0] load_y;
    logic signed [23:0] load_vx;
    logic signed [23:0] load_vy;
    logic        [8:0]  load_life;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic        [8:0]  life_left;
    logic               alive;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_DIVF,
    ST_DIVNX,
    ST_MULX,
    ST_DIVNY,
    ST_MULY,
    ST_DAMPX,
    ST_DAMPY,
    ST_POS,
    ST_OUT
  } state_t;
endpackage

// File: rtl/central_attractor_particle_step.sv
// Channel  | Direction | Handshake           | Payload
// in       | input     | in_valid/in_stall   | in_item_t
// out      | output    | out_valid/out_stall | out_item_t
// cfg      | input     | APB (psel/penable)  | center_x, center_y, gravity
// A load goes straight to ST_OUT. A tick holds the input closed through the
// 50-bit square root (25 steps) and three 64-step restoring divisions that
// run one bit per cycle (the divisions in one shared unit) and dominate.
// Reset is synchronous; it clears state, center, out_valid; gravity=4096.
// in_stall is high from acceptance until the result enters the output
// register; a result still waiting there holds the sequencer in ST_OUT.
module central_attractor_particle_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  cap_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cap_pkg::out_item_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import cap_pkg::*;

  logic signed [23:0] center_x, center_y;
  logic [15:0] gravity;
  logic signed [23:0] position_x, position_y, velocity_x, velocity_y;
  logic [8:0] life_count;
  state_t state, state_next;

  // shared datapath registers
  logic [47:0] sq_x;        // dx*dx
  logic [49:0] dsq;         // softened distance squared
  logic [24:0] root;
  logic [24:0] pull_f;      // gravity term, stays below 2^22
  logic [35:0] norm;
  logic signed [23:0] dxr, dyr;
  logic [63:0] rem;         // division remainder
  logic [63:0] quo;
  logic [63:0] dvd;         // dividend shifting in
  logic [63:0] dvs;
  logic [6:0] cnt;
  logic [48:0] sq_r;        // sqrt remainder

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      RegCenterX: prdata = {{8{center_x[23]}}, center_x};
      RegCenterY: prdata = {{8{center_y[23]}}, center_y};
      RegGravity: prdata = {16'd0, gravity};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      gravity  <= 16'd4096;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        RegCenterX: center_x <= pwdata[23:0];
        RegCenterY: center_y <= pwdata[23:0];
        RegGravity: gravity  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // offsets and magnitudes
  logic signed [24:0] dx_w, dy_w;
  logic [24:0] mx, my;
  assign dx_w = 25'(center_x) - 25'(position_x);
  assign dy_w = 25'(center_y) - 25'(position_y);
  assign mx = dx_w[24] ? 25'(-dx_w) : dx_w;
  assign my = dy_w[24] ? 25'(-dy_w) : dy_w;
  logic signed [24:0] dxs, dys;
  assign dxs = 25'(dxr);

  // shared multiplier: one 36x25 product
  logic [35:0] mul_a;
  logic [24:0] mul_b;
  logic [60:0] mul_p;
  assign mul_p = 61'(mul_a) * 61'(mul_b);

  // softened distance squared
  logic [49:0] dsq_w;
  assign dsq_w = 50'(sq_x) + 50'(mul_p[47:0]) + (50'(Soften) << (2 * FracBits));

  // one restoring division step
  logic [64:0] trial;
  logic [63:0] rem_sh;
  assign rem_sh = {rem[62:0], dvd[63]};
  assign trial = {1'b0, rem_sh} - {1'b0, dvs};

  // sqrt step
  logic [50:0] sq_trial;
  logic [50:0] sq_rsh;
  assign sq_rsh = {sq_r, dvd[63:62]};
  assign sq_trial = sq_rsh - {24'd0, root, 2'b01};

  logic acc_neg;
  assign dys = 25'(dyr);

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state != ST_IDLE);

  // saturating helper
  function automatic logic [23:0] sat24(input logic signed [25:0] v);
    if (v > 26'sd8388607) return Max24;
    else if (v < -26'sd8388608) return Min24;
    else return v[23:0];
  endfunction

  logic signed [25:0] vsum;
  logic [60:0] accm;
  assign accm = mul_p >> FracBits;

  always_comb begin
    mul_a = norm;
    mul_b = pull_f;
    unique case (state)
      ST_SQX: begin mul_a = 36'(mx); mul_b = mx; end
      ST_SQY: begin mul_a = 36'(my); mul_b = my; end
      ST_DAMPX: begin
        mul_a = {12'd0, (velocity_x[23] ? 24'(-velocity_x) : 24'(velocity_x))};
        mul_b = 25'(DampQ16);
      end
      ST_DAMPY: begin
        mul_a = {12'd0, (velocity_y[23] ? 24'(-velocity_y) : 24'(velocity_y))};
        mul_b = 25'(DampQ16);
      end
      default: ;
    endcase
  end

  // signed velocity plus acceleration
  always_comb begin
    acc_neg = (state == ST_MULX) ? dxs[24] : dys[24];
    if (state == ST_MULX)
      vsum = 26'(velocity_x) + (acc_neg ? -26'(accm[25:0]) : 26'(accm[25:0]));
    else
      vsum = 26'(velocity_y) + (acc_neg ? -26'(accm[25:0]) : 26'(accm[25:0]));
    if (accm[60:25] != '0)
      vsum = acc_neg ? -26'sd16777216 : 26'sd16777215;
  end

  logic div_done;
  assign div_done = (cnt == 7'd0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_acc) state_next = (in_data.cmd == CMD_LOAD) ? ST_OUT : ST_SQX;
      ST_SQX:   state_next = ST_SQY;
      ST_SQY:   state_next = ST_SQRT;
      ST_SQRT:  if (div_done) state_next = ST_DIVF;
      ST_DIVF:  if (div_done) state_next = ST_DIVNX;
      ST_DIVNX: if (div_done) state_next = ST_MULX;
      ST_MULX:  state_next = ST_DIVNY;
      ST_DIVNY: if (div_done) state_next = ST_MULY;
      ST_MULY:  state_next = ST_DAMPX;
      ST_DAMPX: state_next = ST_DAMPY;
      ST_DAMPY: state_next = ST_POS;
      ST_POS:   state_next = ST_OUT;
      ST_OUT:   if (!out_valid || out_acc) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == ST_OUT && (!out_valid || out_acc)) out_valid <= 1'b1;
    else if (out_acc) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || out_acc)) begin
      out_data.pos_x     <= position_x;
      out_data.pos_y     <= position_y;
      out_data.life_left <= life_count;
      out_data.alive     <= (life_count != 9'd0);
    end
  end

  // datapath sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      position_x <= '0; position_y <= '0;
      velocity_x <= '0; velocity_y <= '0;
      life_count <= '0;
      cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_acc) begin
          if (in_data.cmd == CMD_LOAD) begin
            position_x <= in_data.load_x; position_y <= in_data.load_y;
            velocity_x <= in_data.load_vx; velocity_y <= in_data.load_vy;
            life_count <= in_data.load_life;
          end
        end
        ST_SQX: begin
          sq_x <= mul_p[47:0];
          dxr  <= dx_w[24] ? -24'sd1 : 24'sd0;
          dyr  <= dy_w[24] ? -24'sd1 : 24'sd0;
        end
        ST_SQY: begin
          dsq  <= dsq_w;
          dvd  <= {dsq_w, 14'd0};
          sq_r <= '0; root <= '0;
          cnt  <= 7'd25;
        end
        ST_SQRT: begin
          if (!div_done) begin
            if (!sq_trial[50]) begin
              sq_r <= sq_trial[48:0]; root <= {root[23:0], 1'b1};
            end else begin
              sq_r <= sq_rsh[48:0]; root <= {root[23:0], 1'b0};
            end
            dvd <= {dvd[61:0], 2'b00};
            cnt <= cnt - 7'd1;
          end else begin
            // gravity term = gravity*Gain << (3F-12) / dsq
            dvd <= 64'(28'(gravity) * 28'(Gain)) << (3 * FracBits - GravFrac);
            dvs <= 64'(dsq);
            rem <= '0; quo <= '0; cnt <= 7'd64;
          end
        end
        ST_DIVF, ST_DIVNX, ST_DIVNY: begin
          if (!div_done) begin
            if (!trial[64]) begin rem <= trial[63:0]; quo <= {quo[62:0], 1'b1}; end
            else begin rem <= rem_sh; quo <= {quo[62:0], 1'b0}; end
            dvd <= {dvd[62:0], 1'b0};
            cnt <= cnt - 7'd1;
          end else begin
            if (state == ST_DIVF) begin
              pull_f <= quo[24:0];
              dvd <= 64'(mx) << FracBits;
            end else begin
              norm <= quo[35:0];
              dvd <= 64'(my) << FracBits;
            end
            dvs <= 64'(root);
            rem <= '0; quo <= '0; cnt <= 7'd64;
          end
        end
        ST_MULX: velocity_x <= sat24(vsum);
        ST_MULY: velocity_y <= sat24(vsum);
        ST_DAMPX: velocity_x <= velocity_x[23] ? -24'(mul_p[39:16]) : 24'(mul_p[39:16]);
        ST_DAMPY: velocity_y <= velocity_y[23] ? -24'(mul_p[39:16]) : 24'(mul_p[39:16]);
        ST_POS: begin
          position_x <= sat24(26'(position_x) + 26'(velocity_x));
          position_y <= sat24(26'(position_y) + 26'(velocity_y));
          if (life_count != 9'd0) life_count <= life_count - 9'd1;
        end
        default: ;
      endcase
    end
  end
endmodule

// File: rtl/cap_checker.sv
`include "assert_macros.svh"
module cap_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input cap_pkg::out_item_t out_data
);
  import cap_pkg::*;
  // alive follows life
  `CHK_IMPLY(a_alive, clk, rst, out_valid, out_data.alive == (out_data.life_left != 9'd0))
  // stalled result holds
  `CHK_NEXT(a_hold, clk, rst, out_valid && out_stall, $stable(out_data) && out_valid)
  // a presented result carries no unknown bits
  `CHK_IMPLY(a_known, clk, rst, out_valid, !$isunknown(out_data))
  // an accepted item closes the input
  `CHK_NEXT(a_close, clk, rst, in_valid && !in_stall, in_stall)
endmodule

bind central_attractor_particle_step cap_checker u_cap_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// File: sim/central_attractor_particle_step_tb.sv
`timescale 1ns / 1ps

module central_attractor_particle_step_tb;
  import cap_pkg::*;

  localparam int TickCycles = 200;
  localparam longint CycleLimit = 4000000;
  localparam int ItemBits = $bits(in_item_t);

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  int errors;
  longint cycles;
  int n_loads;
  int n_ticks;
  bit hold_out;

  central_attractor_particle_step u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Particle predictor and queue of expected results
  class particle_scoreboard;
    logic signed [23:0] ctr_x, ctr_y;
    logic [15:0] grav;
    longint px, py, vx, vy;
    int life;
    out_item_t pending[$];

    function new();
      ctr_x = 0; ctr_y = 0; grav = 16'd4096;
      px = 0; py = 0; vx = 0; vy = 0; life = 0;
    endfunction

    function longint clamp24(input longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    function longint unsigned root64(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint pull(input longint d, input longint unsigned f,
                          input longint unsigned s);
      longint unsigned m, nrm, a;
      m = d < 0 ? -d : d;
      nrm = (m << FracBits) / s;
      a = (nrm * f) >> FracBits;
      return d < 0 ? -longint'(a) : longint'(a);
    endfunction

    function longint damped(input longint v);
      longint unsigned m;
      m = ((v < 0 ? -v : v) * 65012) >> 16;
      return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function void note_item(input in_item_t it);
      longint dx, dy;
      longint unsigned dsq, s, f, mx, my;
      out_item_t e;
      if (it.cmd) begin
        px = it.load_x; py = it.load_y; vx = it.load_vx; vy = it.load_vy;
        life = it.load_life;
      end else begin
        dx = longint'(ctr_x) - px;
        dy = longint'(ctr_y) - py;
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        dsq = mx * mx + my * my + (64'd120 << (2 * FracBits));
        s = root64(dsq);
        f = ((longint'(grav) * 2200) << (3 * FracBits - GravFrac)) / dsq;
        vx = damped(clamp24(vx + pull(dx, f, s)));
        vy = damped(clamp24(vy + pull(dy, f, s)));
        px = clamp24(px + vx);
        py = clamp24(py + vy);
        if (life > 0) life--;
      end
      e.pos_x = px[23:0];
      e.pos_y = py[23:0];
      e.life_left = life[8:0];
      e.alive = life > 0;
      pending.push_back(e);
    endfunction

    task check_result(input out_item_t got);
      out_item_t w;
      if (pending.size() == 0) begin
        report("unexpected result", got.pos_x, 0);
        return;
      end
      w = pending.pop_front();
      if (got.pos_x !== w.pos_x) report("pos_x", got.pos_x, w.pos_x);
      if (got.pos_y !== w.pos_y) report("pos_y", got.pos_y, w.pos_y);
      if (got.life_left !== w.life_left) report("life_left", got.life_left, w.life_left);
      if (got.alive !== w.alive) report("alive", got.alive, w.alive);
    endtask
  endclass

  particle_scoreboard sb;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sampling at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      cycles <= cycles + 1;
      if (in_valid && !in_stall) sb.note_item(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (cycles > CycleLimit) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Result stall: random gaps, or held high while hold_out is set
  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (hold_out) out_stall <= 1'b1;
    else if (r < 25) out_stall <= 1'b1;
    else if (r < 27) out_stall <= 1'b1;
    else out_stall <= 1'b0;
  end

  task automatic idle_cycles(input int n);
    repeat (n) @(negedge clk);
  endtask

  task automatic gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return;
    else if (r < 95) idle_cycles($urandom_range(1, 4));
    else idle_cycles($urandom_range(20, 300));
  endtask

  task automatic send_item(input in_item_t it);
    @(negedge clk);
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
    in_valid <= 1'b0;
    if (it.cmd) n_loads++;
    else n_ticks++;
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegCenterX: sb.ctr_x = val[23:0];
      RegCenterY: sb.ctr_y = val[23:0];
      RegGravity: sb.grav = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    idle_cycles(TickCycles);
  endtask

  function automatic in_item_t tick_item();
    in_item_t it;
    it = ItemBits'({$urandom, $urandom, $urandom, $urandom});
    it.cmd = CMD_TICK;
    return it;
  endfunction

  function automatic logic [23:0] rand24();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(0, 400000)) - 200000);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic in_item_t load_item(input logic [23:0] x, input logic [23:0] y,
                                         input logic [23:0] vx, input logic [23:0] vy,
                                         input logic [8:0] life);
    in_item_t it;
    it.cmd = CMD_LOAD;
    it.load_x = x; it.load_y = y; it.load_vx = vx; it.load_vy = vy;
    it.load_life = life;
    return it;
  endfunction

  initial begin
    int phase;
    int k;
    sb = new();
    errors = 0; cycles = 0; n_loads = 0; n_ticks = 0; hold_out = 0;
    in_valid = 0; in_data = '0; out_stall = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    rst = 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: reset state ticks, then extremes
    send_item(tick_item());
    send_item(load_item(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 9'h1FF));
    send_item(tick_item());
    send_item(load_item(24'h000000, 24'h000000, 24'h000000, 24'h000000, 9'd1));
    send_item(tick_item());
    send_item(tick_item());
    send_item(load_item(24'h7FFF00, 24'h7FFF00, 24'h7FFFFF, 24'h7FFFFF, 9'd3));
    send_item(tick_item());
    send_item(load_item(24'h800100, 24'h800100, 24'h800000, 24'h800000, 9'd0));
    send_item(tick_item());
    drain();
    reg_write(RegGravity, 32'h0000FFFF);
    reg_write(RegCenterX, 32'h007FFFFF);
    reg_write(RegCenterY, 32'hFF800000);
    reg_write(2'd3, 32'hFFFFFFFF);
    send_item(load_item(24'h800000, 24'h7FFFFF, 24'h0, 24'h0, 9'd2));
    send_item(tick_item());
    send_item(load_item(24'h7FFFFF, 24'h800000, 24'h0, 24'h0, 9'd2));
    send_item(tick_item());
    send_item(tick_item());
    drain();
    reg_write(RegGravity, 32'h0);
    send_item(tick_item());
    drain();

    // Random phases with new settings between them
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: reg_write(RegGravity, $urandom_range(0, 65535));
        1: reg_write(RegGravity, (phase == 1) ? 32'hFFFF : 32'h1000);
        2: reg_write(RegGravity, 32'h0);
        default: reg_write(RegGravity, $urandom_range(1, 20000));
      endcase
      reg_write(RegCenterX, {$urandom} >> (phase % 2 ? 8 : 0));
      reg_write(RegCenterY, rand24());
      for (k = 0; k < 115; k++) begin
        if ($urandom_range(0, 9) < 2)
          send_item(load_item(rand24(), rand24(), rand24(),
                              ($urandom_range(0, 1) ? rand24() : 24'($urandom_range(0, 8000))),
                              9'($urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                                                           : $urandom_range(0, 6))));
        else
          send_item(tick_item());
        gap();
        // receiver holds off while the sender keeps offering
        if (phase == 3 && k == 40) begin
          hold_out = 1;
          fork
            begin
              idle_cycles(600);
              hold_out = 0;
            end
          join_none
        end
      end
      drain();
    end

    $display("Covered %0d loads and %0d ticks over 8 register settings plus extremes.",
             n_loads, n_ticks);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
